FILE: sv/rstc_pkg.sv
`default_nettype none
package rstc_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned ScaleW  = 8;
  localparam int unsigned ClipSzW = 31;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned WideW   = 42;

  localparam logic [ScaleW-1:0] STROKE_MAX = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ZOOM      = 3'd2,
    REG_CLIP_LEFT = 3'd3,
    REG_CLIP_TOP  = 3'd4,
    REG_CLIP_W    = 3'd5,
    REG_CLIP_H    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pan_x;
    logic signed [CoordW-1:0] pan_y;
    logic        [ScaleW-1:0] zoom;
    logic signed [CoordW-1:0] clip_left;
    logic signed [CoordW-1:0] clip_top;
    logic signed [CoordW-1:0] clip_w;
    logic signed [CoordW-1:0] clip_h;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] w;
    logic signed [CoordW-1:0] h;
    logic signed [CoordW-1:0] cl;
    logic signed [CoordW-1:0] ct;
    logic signed [CoordW-1:0] cw;
    logic signed [CoordW-1:0] ch;
    logic        [ScaleW-1:0] stroke;
  } item_t;

  typedef struct packed {
    logic                     ok;
    logic                     own_en;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] w;
    logic signed [CoordW-1:0] h;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic signed [CoordW-1:0] ew;
    logic signed [CoordW-1:0] eh;
    logic        [ScaleW-1:0] stroke;
  } scaled_t;

  function automatic logic signed [WideW-1:0] scale_shift(
    input logic signed [CoordW-1:0] v,
    input logic        [ScaleW-1:0] s,
    input logic signed [CoordW-1:0] off
  );
    logic signed [WideW-1:0] s_w;
    s_w = $signed({{(WideW-ScaleW){1'b0}}, s});
    return WideW'(v) * s_w + WideW'(off);
  endfunction

  function automatic logic fits_i32(input logic signed [WideW-1:0] v);
    return (&v[WideW-1:CoordW-1]) | ~(|v[WideW-1:CoordW-1]);
  endfunction

endpackage
`default_nettype wire

FILE: sv/rstc_in_if.sv
`default_nettype none
interface rstc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] item_x;
  logic signed [31:0] item_y;
  logic signed [31:0] item_width;
  logic signed [31:0] item_height;
  logic signed [31:0] own_clip_left;
  logic signed [31:0] own_clip_top;
  logic signed [31:0] own_clip_width;
  logic signed [31:0] own_clip_height;
  logic        [7:0]  stroke_width;

  modport source (output valid, item_x, item_y, item_width, item_height, own_clip_left,
                  output own_clip_top, own_clip_width, own_clip_height, stroke_width,
                  input ready);
  modport sink (input valid, item_x, item_y, item_width, item_height, own_clip_left,
                input own_clip_top, own_clip_width, own_clip_height, stroke_width,
                output ready);
endinterface
`default_nettype wire

FILE: sv/rstc_out_if.sv
`default_nettype none
interface rstc_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_width;
  logic signed [31:0] out_height;
  logic signed [31:0] out_clip_left;
  logic signed [31:0] out_clip_top;
  logic        [30:0] out_clip_width;
  logic        [30:0] out_clip_height;
  logic        [7:0]  out_stroke_width;

  modport source (output valid, accepted, out_x, out_y, out_width, out_height,
                  output out_clip_left, out_clip_top, out_clip_width, out_clip_height,
                  output out_stroke_width, input ready);
  modport sink (input valid, accepted, out_x, out_y, out_width, out_height,
                input out_clip_left, out_clip_top, out_clip_width, out_clip_height,
                input out_stroke_width, output ready);
endinterface
`default_nettype wire

FILE: sv/rect_scale_translate_clip.sv
`default_nettype none
// Scales each drawing item by the zoom register, shifts its position and own clip by the
// view origin, intersects the own clip (when it has a positive size) with the view clip and
// saturates the scaled stroke width at 255. Items that leave the 32-bit signed range, meet
// a zero zoom or a non-positive view clip, or end with an empty clip come out with accepted
// low and every other field zero. One request is taken per cycle unless the stages are
// full; each passes an input register, a register after the scaling multipliers and the
// result register. Each stage moves on whenever the one after it is empty or moving, so
// a stalled result does not stop requests filling the empty stages behind it. The user
// must write registers only while the block holds no request, which is not enforced.
module rect_scale_translate_clip (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [rstc_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire  [rstc_pkg::CoordW-1:0]  cfg_wdata,
  rstc_in_if.sink                      in_ch,
  rstc_out_if.source                   out_ch
);
  import rstc_pkg::*;

  cfg_t    cfg_r;
  item_t   s1_r;
  logic    s1_v_r;
  scaled_t s2_r, s2_nxt;
  logic    s2_v_r;
  logic    out_v_r;

  logic                     acc_r, acc_nxt;
  logic signed [CoordW-1:0] ox_r, oy_r, ow_r, oh_r, ocl_r, oct_r;
  logic signed [CoordW-1:0] ox_nxt, oy_nxt, ow_nxt, oh_nxt, ocl_nxt, oct_nxt;
  logic [ClipSzW-1:0]       ocw_r, och_r, ocw_nxt, och_nxt;
  logic [ScaleW-1:0]        osw_r, osw_nxt;

  logic out_adv, s2_adv, s1_adv;

  assign out_adv     = !out_v_r || out_ch.ready;
  assign s2_adv      = !s2_v_r || out_adv;
  assign s1_adv      = !s1_v_r || s2_adv;
  assign in_ch.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pan_x     <= '0;
      cfg_r.pan_y     <= '0;
      cfg_r.zoom      <= ScaleW'(1);
      cfg_r.clip_left <= '0;
      cfg_r.clip_top  <= '0;
      cfg_r.clip_w    <= '0;
      cfg_r.clip_h    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ORIGIN_X:  cfg_r.pan_x     <= cfg_wdata;
        REG_ORIGIN_Y:  cfg_r.pan_y     <= cfg_wdata;
        REG_ZOOM:      cfg_r.zoom      <= cfg_wdata[ScaleW-1:0];
        REG_CLIP_LEFT: cfg_r.clip_left <= cfg_wdata;
        REG_CLIP_TOP:  cfg_r.clip_top  <= cfg_wdata;
        REG_CLIP_W:    cfg_r.clip_w    <= cfg_wdata;
        REG_CLIP_H:    cfg_r.clip_h    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_ch.valid;
    end
    if (s1_adv && in_ch.valid) begin
      s1_r.x      <= in_ch.item_x;
      s1_r.y      <= in_ch.item_y;
      s1_r.w      <= in_ch.item_width;
      s1_r.h      <= in_ch.item_height;
      s1_r.cl     <= in_ch.own_clip_left;
      s1_r.ct     <= in_ch.own_clip_top;
      s1_r.cw     <= in_ch.own_clip_width;
      s1_r.ch     <= in_ch.own_clip_height;
      s1_r.stroke <= in_ch.stroke_width;
    end
  end

  logic signed [WideW-1:0]  px, py, pw, ph, pex, pey, pew, peh;
  logic [2*ScaleW-1:0]      stroke_prod;
  logic                     cfg_ok, own_en, main_ok, own_ok;

  always_comb begin
    px  = scale_shift(s1_r.x,  cfg_r.zoom, cfg_r.pan_x);
    py  = scale_shift(s1_r.y,  cfg_r.zoom, cfg_r.pan_y);
    pw  = scale_shift(s1_r.w,  cfg_r.zoom, '0);
    ph  = scale_shift(s1_r.h,  cfg_r.zoom, '0);
    pex = scale_shift(s1_r.cl, cfg_r.zoom, cfg_r.pan_x);
    pey = scale_shift(s1_r.ct, cfg_r.zoom, cfg_r.pan_y);
    pew = scale_shift(s1_r.cw, cfg_r.zoom, '0);
    peh = scale_shift(s1_r.ch, cfg_r.zoom, '0);
    stroke_prod = (2*ScaleW)'(s1_r.stroke) * (2*ScaleW)'(cfg_r.zoom);

    cfg_ok  = (cfg_r.zoom != '0) && (cfg_r.clip_w > 0) && (cfg_r.clip_h > 0);
    own_en  = (s1_r.cw > 0) && (s1_r.ch > 0);
    main_ok = fits_i32(px) && fits_i32(py) && fits_i32(pw) && fits_i32(ph);
    own_ok  = fits_i32(pex) && fits_i32(pey) && fits_i32(pew) && fits_i32(peh);

    s2_nxt.ok     = cfg_ok && main_ok && (!own_en || own_ok);
    s2_nxt.own_en = own_en;
    s2_nxt.x      = px[CoordW-1:0];
    s2_nxt.y      = py[CoordW-1:0];
    s2_nxt.w      = pw[CoordW-1:0];
    s2_nxt.h      = ph[CoordW-1:0];
    s2_nxt.ex     = pex[CoordW-1:0];
    s2_nxt.ey     = pey[CoordW-1:0];
    s2_nxt.ew     = pew[CoordW-1:0];
    s2_nxt.eh     = peh[CoordW-1:0];
    s2_nxt.stroke = (|stroke_prod[2*ScaleW-1:ScaleW]) ? STROKE_MAX
                                                      : stroke_prod[ScaleW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_adv && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  logic signed [CoordW:0]   vcr, vcb, er, eb, cr, cb;
  logic signed [CoordW-1:0] cl, ct;
  logic signed [CoordW+1:0] cw, ch;
  logic                     keep;

  always_comb begin
    vcr = (CoordW+1)'(cfg_r.clip_left) + (CoordW+1)'(cfg_r.clip_w);
    vcb = (CoordW+1)'(cfg_r.clip_top) + (CoordW+1)'(cfg_r.clip_h);
    er  = (CoordW+1)'(s2_r.ex) + (CoordW+1)'(s2_r.ew);
    eb  = (CoordW+1)'(s2_r.ey) + (CoordW+1)'(s2_r.eh);
    cl  = (s2_r.own_en && (s2_r.ex > cfg_r.clip_left)) ? s2_r.ex : cfg_r.clip_left;
    ct  = (s2_r.own_en && (s2_r.ey > cfg_r.clip_top)) ? s2_r.ey : cfg_r.clip_top;
    cr  = (s2_r.own_en && (er < vcr)) ? er : vcr;
    cb  = (s2_r.own_en && (eb < vcb)) ? eb : vcb;
    cw  = (CoordW+2)'(cr) - (CoordW+2)'(cl);
    ch  = (CoordW+2)'(cb) - (CoordW+2)'(ct);
    keep = s2_r.ok && (cw > 0) && (ch > 0);

    acc_nxt = keep;
    ox_nxt  = keep ? s2_r.x : '0;
    oy_nxt  = keep ? s2_r.y : '0;
    ow_nxt  = keep ? s2_r.w : '0;
    oh_nxt  = keep ? s2_r.h : '0;
    ocl_nxt = keep ? cl : '0;
    oct_nxt = keep ? ct : '0;
    ocw_nxt = keep ? cw[ClipSzW-1:0] : '0;
    och_nxt = keep ? ch[ClipSzW-1:0] : '0;
    osw_nxt = keep ? s2_r.stroke : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s2_v_r;
    end
    if (out_adv && s2_v_r) begin
      acc_r <= acc_nxt;
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      ow_r  <= ow_nxt;
      oh_r  <= oh_nxt;
      ocl_r <= ocl_nxt;
      oct_r <= oct_nxt;
      ocw_r <= ocw_nxt;
      och_r <= och_nxt;
      osw_r <= osw_nxt;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.accepted         = acc_r;
  assign out_ch.out_x            = ox_r;
  assign out_ch.out_y            = oy_r;
  assign out_ch.out_width        = ow_r;
  assign out_ch.out_height       = oh_r;
  assign out_ch.out_clip_left    = ocl_r;
  assign out_ch.out_clip_top     = oct_r;
  assign out_ch.out_clip_width   = ocw_r;
  assign out_ch.out_clip_height  = och_r;
  assign out_ch.out_stroke_width = osw_r;

  // An accepted result always carries a non-empty clip.
  a_accept_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.accepted |-> (out_ch.out_clip_width != '0) &&
                                        (out_ch.out_clip_height != '0))
    else $error("accepted result with empty clip");

  // A rejected result carries only zero fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.accepted |-> (out_ch.out_x == '0) && (out_ch.out_y == '0) &&
      (out_ch.out_clip_width == '0) && (out_ch.out_stroke_width == '0))
    else $error("rejected result with non-zero fields");

  // Requests are refused only when every stage is occupied.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && s2_v_r && out_v_r)
    else $error("request refused with an empty stage");

  // A request that is taken reaches the second stage on the next move.
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_adv |=> s2_v_r)
    else $error("request lost between stages");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import rstc_pkg::*;

  typedef struct packed {
    logic                     acc;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] w;
    logic signed [CoordW-1:0] h;
    logic signed [CoordW-1:0] cl;
    logic signed [CoordW-1:0] ct;
    logic        [ClipSzW-1:0] cw;
    logic        [ClipSzW-1:0] ch;
    logic        [ScaleW-1:0] sw;
  } rect_res_t;

  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam logic [CoordW-1:0] C_MIN = 32'h8000_0000;
  localparam logic [CoordW-1:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CoordW-1:0] cfg_wdata;

  rstc_in_if  in_if ();
  rstc_out_if out_if ();

  rect_scale_translate_clip u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if.sink),
    .out_ch   (out_if.source)
  );

  item_t     pending_items[$];
  rect_res_t expected_rects[$];
  cfg_t      view_cfg;
  bit        in_fire;
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  rect_res_t exp_rect;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit in_i32(longint v);
    return v >= I32_MIN && v <= I32_MAX;
  endfunction

  function automatic rect_res_t predict_rect(item_t it, cfg_t c);
    rect_res_t r;
    longint z, px, py, pw, ph, ex, ey, ew, eh, cl, ct, cr, cb, stk, dw, dh;
    r = '0;
    z = longint'(c.zoom);
    if (z == 0 || $signed(c.clip_w) <= 0 || $signed(c.clip_h) <= 0) return r;
    px = longint'($signed(it.x)) * z + longint'($signed(c.pan_x));
    py = longint'($signed(it.y)) * z + longint'($signed(c.pan_y));
    pw = longint'($signed(it.w)) * z;
    ph = longint'($signed(it.h)) * z;
    if (!(in_i32(px) && in_i32(py) && in_i32(pw) && in_i32(ph))) return r;
    stk = longint'(it.stroke) * z;
    if (stk > longint'(STROKE_MAX)) stk = longint'(STROKE_MAX);
    cl = longint'($signed(c.clip_left));
    ct = longint'($signed(c.clip_top));
    cr = cl + longint'($signed(c.clip_w));
    cb = ct + longint'($signed(c.clip_h));
    if ($signed(it.cw) > 0 && $signed(it.ch) > 0) begin
      ex = longint'($signed(it.cl)) * z + longint'($signed(c.pan_x));
      ey = longint'($signed(it.ct)) * z + longint'($signed(c.pan_y));
      ew = longint'($signed(it.cw)) * z;
      eh = longint'($signed(it.ch)) * z;
      if (!(in_i32(ex) && in_i32(ey) && in_i32(ew) && in_i32(eh))) return r;
      if (ex > cl) cl = ex;
      if (ey > ct) ct = ey;
      if (ex + ew < cr) cr = ex + ew;
      if (ey + eh < cb) cb = ey + eh;
    end
    dw = cr - cl;
    dh = cb - ct;
    if (dw <= 0 || dh <= 0) return r;
    r.acc = 1'b1;
    r.x   = px[31:0];
    r.y   = py[31:0];
    r.w   = pw[31:0];
    r.h   = ph[31:0];
    r.cl  = cl[31:0];
    r.ct  = ct[31:0];
    r.cw  = dw[30:0];
    r.ch  = dh[30:0];
    r.sw  = stk[7:0];
    return r;
  endfunction

  function automatic logic [31:0] near(longint anchor, int span);
    longint v;
    v = anchor + longint'($urandom_range(0, 2 * span)) - longint'(span);
    return v[31:0];
  endfunction

  function automatic logic [31:0] rim_coord(longint shift);
    longint z, tgt;
    z = longint'(view_cfg.zoom);
    tgt = ($urandom_range(0, 1) == 0) ? I32_MAX : I32_MIN;
    if (z == 0 || $urandom_range(0, 3) == 0) return tgt[31:0];
    tgt = (tgt - shift) / z + longint'($urandom_range(0, 4)) - 64'sd2;
    return tgt[31:0];
  endfunction

  function automatic item_t gen_item();
    item_t it;
    int kind, span;
    longint z, bx, by, ox, oy;
    kind = $urandom_range(0, 9);
    span = 1 << $urandom_range(0, 14);
    z = longint'(view_cfg.zoom);
    ox = longint'($signed(view_cfg.pan_x));
    oy = longint'($signed(view_cfg.pan_y));
    bx = (z == 0) ? 0 : (longint'($signed(view_cfg.clip_left)) - ox) / z;
    by = (z == 0) ? 0 : (longint'($signed(view_cfg.clip_top)) - oy) / z;
    it.x  = near(bx, span);
    it.y  = near(by, span);
    it.w  = near(0, span);
    it.h  = near(0, span);
    it.cl = near(bx, span);
    it.ct = near(by, span);
    it.cw = near(span / 2, span);
    it.ch = near(span / 2, span);
    if (kind >= 8) begin
      it.x  = $urandom;
      it.y  = $urandom;
      it.w  = $urandom;
      it.h  = $urandom;
      it.cl = $urandom;
      it.ct = $urandom;
      it.cw = $urandom;
      it.ch = $urandom;
    end else if (kind >= 6) begin
      case ($urandom_range(0, 7))
        0: it.x  = rim_coord(ox);
        1: it.y  = rim_coord(oy);
        2: it.w  = rim_coord(0);
        3: it.h  = rim_coord(0);
        4: it.cl = rim_coord(ox);
        5: it.ct = rim_coord(oy);
        6: it.cw = rim_coord(0);
        default: it.ch = rim_coord(0);
      endcase
    end
    case ($urandom_range(0, 3))
      0: it.stroke = 8'd0;
      1: it.stroke = 8'd255;
      default: it.stroke = 8'($urandom_range(0, 255));
    endcase
    return it;
  endfunction

  task automatic add_item(logic [31:0] x, logic [31:0] y, logic [31:0] w, logic [31:0] h,
                          logic [31:0] l, logic [31:0] t, logic [31:0] cw, logic [31:0] ch,
                          logic [7:0] s);
    item_t it;
    it = '{x: x, y: y, w: w, h: h, cl: l, ct: t, cw: cw, ch: ch, stroke: s};
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ORIGIN_X:  view_cfg.pan_x     = val;
      REG_ORIGIN_Y:  view_cfg.pan_y     = val;
      REG_ZOOM:      view_cfg.zoom      = val[ScaleW-1:0];
      REG_CLIP_LEFT: view_cfg.clip_left = val;
      REG_CLIP_TOP:  view_cfg.clip_top  = val;
      REG_CLIP_W:    view_cfg.clip_w    = val;
      REG_CLIP_H:    view_cfg.clip_h    = val;
      default: ;
    endcase
  endtask

  task automatic apply_view(logic [31:0] ox, logic [31:0] oy, logic [31:0] z,
                            logic [31:0] l, logic [31:0] t, logic [31:0] w, logic [31:0] h);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ZOOM, z);
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_W, w);
    write_reg(REG_CLIP_H, h);
    write_reg(REG_UNUSED, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_results();
    while (pending_items.size() != 0 || expected_rects.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (6) @(posedge clk);
  endtask

  task automatic check_field(string name, logic signed [63:0] e, logic signed [63:0] a);
    if (e !== a) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
    end
  endtask

  // A request is held on the channel until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!(in_if.valid && !in_fire)) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_if.valid           <= 1'b1;
          in_if.item_x          <= pending_items[0].x;
          in_if.item_y          <= pending_items[0].y;
          in_if.item_width      <= pending_items[0].w;
          in_if.item_height     <= pending_items[0].h;
          in_if.own_clip_left   <= pending_items[0].cl;
          in_if.own_clip_top    <= pending_items[0].ct;
          in_if.own_clip_width  <= pending_items[0].cw;
          in_if.own_clip_height <= pending_items[0].ch;
          in_if.stroke_width    <= pending_items[0].stroke;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    in_fire = 1'b0;
    if (rst_n) begin
      in_fire = in_if.valid && in_if.ready;
      if (in_fire) begin
        expected_rects.push_back(predict_rect(pending_items[0], view_cfg));
        void'(pending_items.pop_front());
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_rects.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual accepted=%0d x=%0d",
                   $time, out_if.accepted, out_if.out_x);
        end else begin
          exp_rect = expected_rects.pop_front();
          check_field("accepted", exp_rect.acc, out_if.accepted);
          check_field("out_x", exp_rect.x, out_if.out_x);
          check_field("out_y", exp_rect.y, out_if.out_y);
          check_field("out_width", exp_rect.w, out_if.out_width);
          check_field("out_height", exp_rect.h, out_if.out_height);
          check_field("out_clip_left", exp_rect.cl, out_if.out_clip_left);
          check_field("out_clip_top", exp_rect.ct, out_if.out_clip_top);
          check_field("out_clip_width", exp_rect.cw, out_if.out_clip_width);
          check_field("out_clip_height", exp_rect.ch, out_if.out_clip_height);
          check_field("out_stroke_width", exp_rect.sw, out_if.out_stroke_width);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_wdata              = '0;
    in_if.valid            = 1'b0;
    in_if.item_x           = '0;
    in_if.item_y           = '0;
    in_if.item_width       = '0;
    in_if.item_height      = '0;
    in_if.own_clip_left    = '0;
    in_if.own_clip_top     = '0;
    in_if.own_clip_width   = '0;
    in_if.own_clip_height  = '0;
    in_if.stroke_width     = '0;
    out_if.ready           = 1'b0;
    in_fire                = 1'b0;
    mismatch_count         = 0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    view_cfg               = '0;
    view_cfg.zoom          = 8'd1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The view clip is empty after reset, so both of these are rejected.
    add_item(1, 2, 3, 4, 0, 0, 0, 0, 8'd10);
    add_item(0, 0, 5, 5, 0, 0, 5, 5, 8'd255);
    settle();

    apply_view(8, -20, 4, -100, -100, 1000, 1000);
    add_item(1, 2, 3, 4, 0, 0, 0, 0, 8'd10);
    add_item(-5, -6, -7, -8, 0, 0, 0, 0, 8'd64);
    add_item(0, 0, 10, 10, 0, 0, 50, 50, 8'd63);
    add_item(0, 0, 1, 1, 0, 0, -1, 50, 8'd1);
    add_item(0, 0, 1, 1, 0, 0, 50, 0, 8'd0);
    add_item(0, 0, 1, 1, 10000, 0, 5, 5, 8'd2);
    add_item(0, 0, 1, 1, 223, 0, 5, 5, 8'd3);
    add_item(0, 0, 1, 1, 222, 0, 5, 5, 8'd3);
    add_item(C_MAX, 0, 1, 1, 0, 0, 0, 0, 8'd5);
    add_item(C_MIN, 0, 1, 1, 0, 0, 0, 0, 8'd5);
    add_item(0, C_MAX, 1, 1, 0, 0, 0, 0, 8'd5);
    add_item(0, 0, C_MIN, 1, 0, 0, 0, 0, 8'd5);
    add_item(0, 0, 1, C_MAX, 0, 0, 0, 0, 8'd5);
    add_item(0, 0, 1, 1, C_MAX, 0, 5, 5, 8'd5);
    add_item(0, 0, 1, 1, 0, 0, C_MAX, 5, 8'd5);
    add_item(0, 0, 1, 1, C_MAX, C_MIN, 0, -3, 8'd5);
    add_item(536870909, 0, 1, 1, 0, 0, 0, 0, 8'd255);
    add_item(536870910, 0, 1, 1, 0, 0, 0, 0, 8'd255);
    add_item(0, -536870907, 1, 1, 0, 0, 0, 0, 8'd7);
    add_item(0, -536870908, 1, 1, 0, 0, 0, 0, 8'd7);
    add_item(0, 0, 536870911, -536870912, 0, 0, 0, 0, 8'd7);
    add_item(0, 0, 1, -536870913, 0, 0, 0, 0, 8'd7);
    settle();

    apply_view(0, 0, 255, C_MIN, C_MIN, C_MAX, C_MAX);
    add_item(1, 1, 1, 1, 0, 0, 0, 0, 8'd1);
    add_item(-8421504, -8421504, 1, 1, -8421504, -8421504, 1, 1, 8'd2);
    add_item(8421505, 0, 1, 1, 0, 0, 0, 0, 8'd0);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: apply_view(0, 0, 1, 0, 0, 32'h0010_0000, 32'h0010_0000);
        1: apply_view(100, -50, 3, -5000, -5000, 60000, 60000);
        2: apply_view($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000, 255,
                      -1000000, -1000000, 2000000, 2000000);
        3: apply_view(C_MIN, C_MAX, 1, C_MIN, C_MIN, C_MAX, C_MAX);
        4: apply_view(C_MAX, C_MIN, 2, C_MAX, C_MAX, C_MAX, C_MAX);
        5: apply_view(7, 7, 0, 0, 0, 1000, 1000);
        6: apply_view(0, 0, 5, 0, 0, -1, 500);
        default: apply_view($urandom, $urandom, $urandom_range(1, 255), $urandom, $urandom,
                            $urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 32'h7FFF_FFFF));
      endcase
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct  = 11;
          recv_stall_pct = 11;
        end
      endcase
      for (int i = 0; i < 225; i++) begin
        if (i == 112) wait_results();
        pending_items.push_back(gen_item());
      end
    end

    wait_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
